// ===== hw/rtl/lu_pkg.sv =====
// ----------------------------------------------------------------------------
// lu_pkg
// Shared types, constants and fixed-point helpers of the LU linear solver.
// ----------------------------------------------------------------------------
package lu_pkg;

    localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;

    localparam logic [4:0] MSIZE_RST = 5'd16;

    // register indexes on the configuration port
    localparam logic REG_MSIZE = 1'b0;
    localparam logic REG_THR   = 1'b1;

    typedef enum logic [5:0] {
        ST_LOAD,
        ST_INIT,
        ST_PV_RD, ST_PV_CMP, ST_PV_CHK,
        ST_SW_RA, ST_SW_RB, ST_SW_WA, ST_SW_WB,
        ST_OS_RA, ST_OS_RB, ST_OS_WA, ST_OS_WB,
        ST_EL_RP, ST_EL_RA, ST_EL_DIV, ST_EL_DW,
        ST_RK_RJ, ST_RK_RI, ST_RK_MUL, ST_RK_WR,
        ST_FW_RO, ST_FW_RR, ST_FW_ACC, ST_FW_RD, ST_FW_MUL, ST_FW_SAT, ST_FW_SUB,
        ST_FW_WR,
        ST_BK_RY, ST_BK_ACC, ST_BK_RD, ST_BK_MUL, ST_BK_SAT, ST_BK_SUB,
        ST_BK_RDG, ST_BK_DIV, ST_BK_DW,
        ST_EM_RD, ST_EM_OUT,
        ST_SING
    } t_state;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d[32] != d[31]) begin
            return d[32] ? QMIN : QMAX;
        end
        return d[31:0];
    endfunction

endpackage

// ===== hw/rtl/lu_req_if.sv =====
// ----------------------------------------------------------------------------
// lu_req_if
// Load request channel: one matrix or right-hand entry per request.
// ----------------------------------------------------------------------------
interface lu_req_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, func, row, col, value, last, input ready);
    modport sink   (input valid, func, row, col, value, last, output ready);
endinterface

// ===== hw/rtl/lu_res_if.sv =====
// ----------------------------------------------------------------------------
// lu_res_if
// Result channel: one solution element or one singular status per request.
// ----------------------------------------------------------------------------
interface lu_res_if;
    logic               valid;
    logic               ready;
    logic [3:0]         index;
    logic signed [31:0] value_res;
    logic               status;
    logic               done_res;

    modport source (output valid, index, value_res, status, done_res, input ready);
    modport sink   (input valid, index, value_res, status, done_res, output ready);
endinterface

// ===== hw/rtl/lu_ram.sv =====
// ----------------------------------------------------------------------------
// lu_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/lu_div.sv =====
// ----------------------------------------------------------------------------
// lu_div
// Fixed-point divider: (num << FRAC_BITS) / den, truncated toward zero and
// saturated to 32 bits. Restoring radix-2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lu_div import lu_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int NW   = 32 + FRAC_BITS;
    localparam int CNTW = $clog2(NW);

    logic            r_busy;
    logic            r_fin;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_num;
    logic [31:0]     r_den;
    logic [31:0]     r_rem;
    logic            r_neg;

    logic [32:0]        trial;
    logic [32:0]        diff;
    logic               ge;
    logic               over_pos;
    logic               over_neg;
    logic signed [31:0] quot;

    assign trial = {r_rem, r_num[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_fin  <= 1'b0;
        end else if (r_busy && (r_cnt == CNTW'(NW - 1))) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b1;
        end else begin
            r_fin  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= {mag32(i_req.num), FRAC_BITS'(0)};
            r_den <= mag32(i_req.den);
            r_rem <= '0;
            r_neg <= i_req.num[31] ^ i_req.den[31];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[31:0] : trial[31:0];
            r_num <= {r_num[NW-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign over_pos = |r_num[NW-1:31];
    assign over_neg = (|r_num[NW-1:32]) || (r_num[31] && (|r_num[30:0]));

    always_comb begin
        if (r_neg) begin
            quot = over_neg ? QMIN : -$signed(r_num[31:0]);
        end else begin
            quot = over_pos ? QMAX : $signed(r_num[31:0]);
        end
    end

    assign o_rsp.done = r_fin;
    assign o_rsp.quot = quot;
endmodule

// ===== hw/rtl/lu_linear_solver.sv =====
// ----------------------------------------------------------------------------
// lu_linear_solver
// Q16.16 linear solver: row-reorder pre-pass, Doolittle LU, forward and
// back substitution, over RAM-resident matrix, factor and vector stores.
// ----------------------------------------------------------------------------
// Load requests are taken one per cycle. The request marked last starts the
// solve, and no further request is taken until its results have all been
// handed to the output register. The solve is bound by a single read port on
// each store and by the bit-serial divider. A singular system ends the run
// early with one status result.
module lu_linear_solver import lu_pkg::*; #(
    parameter int N_MAX     = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lu_req_if.sink      i_req,
    lu_res_if.source    o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW  = $clog2(N_MAX);
    localparam int MAW = $clog2(N_MAX * N_MAX);
    localparam int CW  = $clog2(N_MAX + 1);

    function automatic logic [MAW-1:0] mat_addr(input logic [AW-1:0] r,
                                                input logic [AW-1:0] c);
        return MAW'(32'(r) * N_MAX + 32'(c));
    endfunction

    function automatic logic signed [31:0] mul_sat(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> FRAC_BITS;
        if ((s[63:31] == '0) || (s[63:31] == '1)) begin
            return s[31:0];
        end
        return s[63] ? QMIN : QMAX;
    endfunction

    function automatic logic [CW-1:0] clamp_n(input logic [4:0] ms);
        if (ms == 5'd0) begin
            return CW'(1);
        end
        if (32'(ms) > N_MAX) begin
            return CW'(N_MAX);
        end
        return CW'(ms);
    endfunction

    t_state r_state, n_state;

    logic [4:0]  r_msize;
    logic [30:0] r_thr;

    logic [CW-1:0]      r_n, r_i, r_j, r_k, r_best;
    logic [31:0]        r_cur;
    logic signed [31:0] r_piv, r_m, r_a, r_acc, r_q;
    logic [AW-1:0]      r_ord;
    logic signed [63:0] r_p;

    logic               r_ovalid;
    logic [3:0]         r_oindex;
    logic signed [31:0] r_ovalue;
    logic               r_ostatus;
    logic               r_odone;

    logic [CW-1:0] i_nxt, j_nxt, k_nxt;
    logic          i_end, j_end, k_end;
    logic          req_acc, out_free, cfg_wr;

    logic               mat_we, mul_we, rhs_we, ord_we, vec_we;
    logic [MAW-1:0]     mat_waddr, mat_raddr, mul_waddr, mul_raddr;
    logic [AW-1:0]      rhs_waddr, rhs_raddr, ord_waddr, ord_raddr, vec_waddr, vec_raddr;
    logic signed [31:0] mat_wdata, mul_wdata, rhs_wdata, vec_wdata;
    logic [AW-1:0]      ord_wdata;
    logic [31:0]        mat_rdata, mul_rdata, rhs_rdata, vec_rdata;
    logic [AW-1:0]      ord_rdata;

    logic signed [31:0] mul_x, mul_y;
    logic signed [63:0] prod;
    logic [31:0]        pv_mag;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic               ld_out;
    logic [3:0]         ld_index;
    logic signed [31:0] ld_value;
    logic               ld_status;
    logic               ld_done;

    assign i_nxt = r_i + 1'b1;
    assign j_nxt = r_j + 1'b1;
    assign k_nxt = r_k + 1'b1;
    assign i_end = (i_nxt == r_n);
    assign j_end = (j_nxt == r_n);
    assign k_end = (k_nxt == r_n);

    assign req_acc  = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_res.ready;
    assign pv_mag   = mag32(mat_rdata);

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_MSIZE: prdata = {27'd0, r_msize};
            REG_THR:   prdata = {1'b0, r_thr};
            default:   prdata = '0;
        endcase
    end

    // ---------------- stores ----------------
    lu_ram #(.WIDTH(32), .DEPTH(N_MAX * N_MAX)) u_mat (
        .i_clk(i_clk), .i_we(mat_we), .i_waddr(mat_waddr), .i_wdata(mat_wdata),
        .i_raddr(mat_raddr), .o_rdata(mat_rdata)
    );
    lu_ram #(.WIDTH(32), .DEPTH(N_MAX * N_MAX)) u_mul (
        .i_clk(i_clk), .i_we(mul_we), .i_waddr(mul_waddr), .i_wdata(mul_wdata),
        .i_raddr(mul_raddr), .o_rdata(mul_rdata)
    );
    lu_ram #(.WIDTH(32), .DEPTH(N_MAX)) u_rhs (
        .i_clk(i_clk), .i_we(rhs_we), .i_waddr(rhs_waddr), .i_wdata(rhs_wdata),
        .i_raddr(rhs_raddr), .o_rdata(rhs_rdata)
    );
    lu_ram #(.WIDTH(AW), .DEPTH(N_MAX)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );
    // holds y after forward substitution, then x
    lu_ram #(.WIDTH(32), .DEPTH(N_MAX)) u_vec (
        .i_clk(i_clk), .i_we(vec_we), .i_waddr(vec_waddr), .i_wdata(vec_wdata),
        .i_raddr(vec_raddr), .o_rdata(vec_rdata)
    );

    lu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp)
    );

    // shared multiplier, registered product
    always_comb begin
        case (r_state)
            ST_RK_RI: begin
                mul_x = r_m;
                mul_y = mat_rdata;
            end
            ST_FW_MUL: begin
                mul_x = mul_rdata;
                mul_y = vec_rdata;
            end
            default: begin
                mul_x = mat_rdata;
                mul_y = vec_rdata;
            end
        endcase
    end
    assign prod = mul_x * mul_y;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:   if (req_acc && i_req.last) n_state = ST_INIT;
            ST_INIT:   if (i_end) n_state = ST_PV_RD;
            ST_PV_RD:  n_state = ST_PV_CMP;
            ST_PV_CMP: n_state = j_end ? ST_PV_CHK : ST_PV_RD;
            ST_PV_CHK: begin
                if (r_cur <= {1'b0, r_thr}) begin
                    n_state = ST_SING;
                end else if (r_best != r_i) begin
                    n_state = ST_SW_RA;
                end else if (!i_end) begin
                    n_state = ST_PV_RD;
                end else begin
                    n_state = (r_n > CW'(1)) ? ST_EL_RP : ST_FW_RO;
                end
            end
            ST_SW_RA:  n_state = ST_SW_RB;
            ST_SW_RB:  n_state = ST_SW_WA;
            ST_SW_WA:  n_state = ST_SW_WB;
            ST_SW_WB:  n_state = k_end ? ST_OS_RA : ST_SW_RA;
            ST_OS_RA:  n_state = ST_OS_RB;
            ST_OS_RB:  n_state = ST_OS_WA;
            ST_OS_WA:  n_state = ST_OS_WB;
            ST_OS_WB: begin
                if (!i_end) begin
                    n_state = ST_PV_RD;
                end else begin
                    n_state = (r_n > CW'(1)) ? ST_EL_RP : ST_FW_RO;
                end
            end
            ST_EL_RP:  n_state = ST_EL_RA;
            ST_EL_RA:  n_state = ST_EL_DIV;
            ST_EL_DIV: n_state = (r_piv == '0) ? ST_SING : ST_EL_DW;
            ST_EL_DW:  if (div_rsp.done) n_state = ST_RK_RJ;
            ST_RK_RJ:  n_state = ST_RK_RI;
            ST_RK_RI:  n_state = ST_RK_MUL;
            ST_RK_MUL: n_state = ST_RK_WR;
            ST_RK_WR: begin
                if (!k_end) begin
                    n_state = ST_RK_RJ;
                end else if ((j_nxt == r_i) && i_end) begin
                    n_state = ST_FW_RO;
                end else begin
                    n_state = ST_EL_RP;
                end
            end
            ST_FW_RO:  n_state = ST_FW_RR;
            ST_FW_RR:  n_state = ST_FW_ACC;
            ST_FW_ACC: n_state = (r_i == '0) ? ST_FW_WR : ST_FW_RD;
            ST_FW_RD:  n_state = ST_FW_MUL;
            ST_FW_MUL: n_state = ST_FW_SAT;
            ST_FW_SAT: n_state = ST_FW_SUB;
            ST_FW_SUB: n_state = (j_nxt == r_i) ? ST_FW_WR : ST_FW_RD;
            ST_FW_WR:  n_state = i_end ? ST_BK_RY : ST_FW_RO;
            ST_BK_RY:  n_state = ST_BK_ACC;
            ST_BK_ACC: n_state = i_end ? ST_BK_RDG : ST_BK_RD;
            ST_BK_RD:  n_state = ST_BK_MUL;
            ST_BK_MUL: n_state = ST_BK_SAT;
            ST_BK_SAT: n_state = ST_BK_SUB;
            ST_BK_SUB: n_state = j_end ? ST_BK_RDG : ST_BK_RD;
            ST_BK_RDG: n_state = ST_BK_DIV;
            ST_BK_DIV: n_state = (mat_rdata == '0) ? ST_SING : ST_BK_DW;
            ST_BK_DW: begin
                if (div_rsp.done) begin
                    n_state = (r_i == '0) ? ST_EM_RD : ST_BK_RY;
                end
            end
            ST_EM_RD:  n_state = ST_EM_OUT;
            ST_EM_OUT: if (out_free) n_state = i_end ? ST_LOAD : ST_EM_RD;
            ST_SING:   if (out_free) n_state = ST_LOAD;
            default:   n_state = ST_LOAD;
        endcase
    end

    // ---------------- outputs: store ports, divider, result load ----------------
    always_comb begin
        i_req.ready = (r_state == ST_LOAD);

        mat_we = 1'b0; mat_waddr = '0; mat_wdata = '0; mat_raddr = '0;
        mul_we = 1'b0; mul_waddr = '0; mul_wdata = '0; mul_raddr = '0;
        rhs_we = 1'b0; rhs_waddr = '0; rhs_wdata = '0; rhs_raddr = '0;
        ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
        vec_we = 1'b0; vec_waddr = '0; vec_wdata = '0; vec_raddr = '0;

        div_req.start = 1'b0;
        div_req.num   = mat_rdata;
        div_req.den   = r_piv;

        ld_out    = 1'b0;
        ld_index  = '0;
        ld_value  = '0;
        ld_status = 1'b0;
        ld_done   = 1'b0;

        case (r_state)
            ST_LOAD: begin
                mat_waddr = mat_addr(AW'(i_req.row), AW'(i_req.col));
                mat_wdata = i_req.value;
                mat_we    = req_acc && !i_req.func && (32'(i_req.row) < N_MAX)
                            && (32'(i_req.col) < N_MAX);
                rhs_waddr = AW'(i_req.row);
                rhs_wdata = i_req.value;
                rhs_we    = req_acc && i_req.func && (32'(i_req.row) < N_MAX);
            end
            ST_INIT: begin
                ord_we    = 1'b1;
                ord_waddr = r_i[AW-1:0];
                ord_wdata = r_i[AW-1:0];
            end
            ST_PV_RD: mat_raddr = mat_addr(r_j[AW-1:0], r_i[AW-1:0]);
            ST_SW_RA: mat_raddr = mat_addr(r_i[AW-1:0], r_k[AW-1:0]);
            ST_SW_RB: mat_raddr = mat_addr(r_best[AW-1:0], r_k[AW-1:0]);
            ST_SW_WA: begin
                mat_we    = 1'b1;
                mat_waddr = mat_addr(r_i[AW-1:0], r_k[AW-1:0]);
                mat_wdata = mat_rdata;
            end
            ST_SW_WB: begin
                mat_we    = 1'b1;
                mat_waddr = mat_addr(r_best[AW-1:0], r_k[AW-1:0]);
                mat_wdata = r_a;
            end
            ST_OS_RA: ord_raddr = r_i[AW-1:0];
            ST_OS_RB: ord_raddr = r_best[AW-1:0];
            ST_OS_WA: begin
                ord_we    = 1'b1;
                ord_waddr = r_i[AW-1:0];
                ord_wdata = ord_rdata;
            end
            ST_OS_WB: begin
                ord_we    = 1'b1;
                ord_waddr = r_best[AW-1:0];
                ord_wdata = r_ord;
            end
            ST_EL_RP: mat_raddr = mat_addr(r_j[AW-1:0], r_j[AW-1:0]);
            ST_EL_RA: mat_raddr = mat_addr(r_i[AW-1:0], r_j[AW-1:0]);
            ST_EL_DIV: div_req.start = (r_piv != '0);
            ST_EL_DW: begin
                mul_we    = div_rsp.done;
                mul_waddr = mat_addr(r_i[AW-1:0], r_j[AW-1:0]);
                mul_wdata = div_rsp.quot;
            end
            ST_RK_RJ: mat_raddr = mat_addr(r_j[AW-1:0], r_k[AW-1:0]);
            ST_RK_RI: mat_raddr = mat_addr(r_i[AW-1:0], r_k[AW-1:0]);
            ST_RK_WR: begin
                mat_we    = 1'b1;
                mat_waddr = mat_addr(r_i[AW-1:0], r_k[AW-1:0]);
                mat_wdata = sat_sub(r_a, r_q);
            end
            ST_FW_RO: ord_raddr = r_i[AW-1:0];
            ST_FW_RR: rhs_raddr = ord_rdata;
            ST_FW_RD: begin
                mul_raddr = mat_addr(r_i[AW-1:0], r_j[AW-1:0]);
                vec_raddr = r_j[AW-1:0];
            end
            ST_FW_WR: begin
                vec_we    = 1'b1;
                vec_waddr = r_i[AW-1:0];
                vec_wdata = r_acc;
            end
            ST_BK_RY: vec_raddr = r_i[AW-1:0];
            ST_BK_RD: begin
                mat_raddr = mat_addr(r_i[AW-1:0], r_j[AW-1:0]);
                vec_raddr = r_j[AW-1:0];
            end
            ST_BK_RDG: mat_raddr = mat_addr(r_i[AW-1:0], r_i[AW-1:0]);
            ST_BK_DIV: begin
                div_req.start = (mat_rdata != '0);
                div_req.num   = r_acc;
                div_req.den   = mat_rdata;
            end
            ST_BK_DW: begin
                vec_we    = div_rsp.done;
                vec_waddr = r_i[AW-1:0];
                vec_wdata = div_rsp.quot;
            end
            ST_EM_RD: vec_raddr = r_i[AW-1:0];
            ST_EM_OUT: begin
                vec_raddr = r_i[AW-1:0];
                ld_out    = out_free;
                ld_index  = 4'(r_i);
                ld_value  = vec_rdata;
                ld_done   = i_end;
            end
            ST_SING: begin
                ld_out    = out_free;
                ld_status = 1'b1;
                ld_done   = 1'b1;
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_msize  <= MSIZE_RST;
            r_thr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_MSIZE: r_msize <= pwdata[4:0];
                    REG_THR:   r_thr   <= pwdata[30:0];
                    default:   ;
                endcase
            end
            if (ld_out) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------- datapath and loop counters ----------------
    always_ff @(posedge i_clk) begin
        r_p <= prod;
        r_q <= mul_sat(r_p);

        if (ld_out) begin
            r_oindex  <= ld_index;
            r_ovalue  <= ld_value;
            r_ostatus <= ld_status;
            r_odone   <= ld_done;
        end

        case (r_state)
            ST_LOAD: begin
                if (req_acc && i_req.last) begin
                    r_n <= clamp_n(r_msize);
                    r_i <= '0;
                end
            end
            ST_INIT: begin
                r_i <= i_end ? '0 : i_nxt;
                r_j <= '0;
            end
            ST_PV_CMP: begin
                if ((r_j == r_i) || (pv_mag > r_cur)) begin
                    r_cur  <= pv_mag;
                    r_best <= r_j;
                end
                r_j <= j_nxt;
            end
            ST_PV_CHK: begin
                r_k <= '0;
                if (r_best == r_i) begin
                    if (i_end) begin
                        r_i <= (r_n > CW'(1)) ? CW'(1) : '0;
                        r_j <= '0;
                    end else begin
                        r_i <= i_nxt;
                        r_j <= i_nxt;
                    end
                end
            end
            ST_SW_RB: r_a <= mat_rdata;
            ST_SW_WB: r_k <= k_nxt;
            ST_OS_RB: r_ord <= ord_rdata;
            ST_OS_WB: begin
                if (i_end) begin
                    r_i <= (r_n > CW'(1)) ? CW'(1) : '0;
                    r_j <= '0;
                end else begin
                    r_i <= i_nxt;
                    r_j <= i_nxt;
                end
            end
            ST_EL_RA: r_piv <= mat_rdata;
            ST_EL_DW: begin
                if (div_rsp.done) begin
                    r_m <= div_rsp.quot;
                    r_k <= '0;
                end
            end
            ST_RK_MUL: r_a <= mat_rdata;
            ST_RK_WR: begin
                r_k <= k_nxt;
                if (k_end) begin
                    if (j_nxt == r_i) begin
                        r_i <= i_end ? '0 : i_nxt;
                        r_j <= '0;
                    end else begin
                        r_j <= j_nxt;
                    end
                end
            end
            ST_FW_ACC: begin
                r_acc <= rhs_rdata;
                r_j   <= '0;
            end
            ST_FW_SUB: begin
                r_acc <= sat_sub(r_acc, r_q);
                r_j   <= j_nxt;
            end
            // hold i at n-1 for the back pass
            ST_FW_WR: if (!i_end) r_i <= i_nxt;
            ST_BK_ACC: begin
                r_acc <= vec_rdata;
                r_j   <= i_nxt;
            end
            ST_BK_SUB: begin
                r_acc <= sat_sub(r_acc, r_q);
                r_j   <= j_nxt;
            end
            ST_BK_DW: begin
                if (div_rsp.done && (r_i != '0)) begin
                    r_i <= r_i - 1'b1;
                end
            end
            ST_EM_OUT: if (out_free) r_i <= i_nxt;
            default: ;
        endcase
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.index     = r_oindex;
    assign o_res.value_res = r_ovalue;
    assign o_res.status    = r_ostatus;
    assign o_res.done_res  = r_odone;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lu_linear_solver: loads Q16.16 systems over the
// request channel, predicts solutions or singular status in a local model of
// the reorder, elimination and substitution steps, and checks every result.
// ----------------------------------------------------------------------------
module tb import lu_pkg::*; ();

    localparam logic FN_MAT = 1'b0;
    localparam logic FN_VEC = 1'b1;
    localparam int   ONE    = 65536;
    localparam int   WD_LIMIT = 100000;
    localparam int   HOLD_LEN = 400;

    typedef struct {
        logic [3:0]         index;
        logic signed [31:0] value;
        logic               status;
        logic               done;
    } t_sol;

    typedef struct {
        int sz; int thr; int f; int r; int c; int v; int l; int ek; int ev;
    } t_dir_row;

    typedef struct {
        logic f; logic [3:0] r; logic [3:0] c; int v;
    } t_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lu_req_if rq ();
    lu_res_if rs ();

    lu_linear_solver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rq),
        .o_res   (rs),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // solver state as seen by the host
    int         a_mat [256];
    int         l_mul [256];
    int         b_vec [16];
    int         row_ord [16];
    int         x_sol [16];
    bit         mat_wr [256];
    bit         vec_wr [16];
    logic [4:0]  cfg_size = MSIZE_RST;
    logic [30:0] cfg_thr = '0;

    t_sol pending_sol [$];
    int   n_errors = 0;
    int   n_loads = 0, n_solves = 0, n_results = 0, n_singular = 0;
    int   burst_left = 0;
    int   hold_asks = 0, hold_seen = 0, hold_cnt = 0;
    int   rx_mode = 0, rx_left = 0;
    int   idle_cycles = 0;

    function automatic int clip(longint v);
        if (v > longint'(QMAX)) return QMAX;
        if (v < longint'(QMIN)) return QMIN;
        return int'(v);
    endfunction

    function automatic int q_product(int a, int b);
        return clip((longint'(a) * longint'(b)) >>> 16);
    endfunction

    function automatic int q_quotient(int a, int b);
        return clip((longint'(a) * 65536) / longint'(b));
    endfunction

    function automatic int q_diff(int a, int b);
        return clip(longint'(a) - longint'(b));
    endfunction

    function automatic longint magn(int v);
        return v < 0 ? -longint'(v) : longint'(v);
    endfunction

    function automatic t_sol singular_sol();
        t_sol s;
        s.index = '0; s.value = '0; s.status = 1'b1; s.done = 1'b1;
        return s;
    endfunction

    function automatic int eff_size();
        if (cfg_size == 0) return 1;
        if (cfg_size > 16) return 16;
        return int'(cfg_size);
    endfunction

    // reorder, eliminate, substitute; the stores change as in the block
    function automatic void lu_solve_predict(ref t_sol res [$]);
        int n, i, j, k, best, t, mlt, acc, d;
        longint cur, m;
        int y [16];
        t_sol s;
        res.delete();
        n = eff_size();
        for (i = 0; i < n; i++) row_ord[i] = i;
        for (i = 0; i < n; i++) begin
            best = i;
            cur = magn(a_mat[i*16+i]);
            for (j = i + 1; j < n; j++) begin
                m = magn(a_mat[j*16+i]);
                if (m > cur) begin
                    cur = m;
                    best = j;
                end
            end
            if (cur <= longint'(cfg_thr)) begin
                res.push_back(singular_sol());
                return;
            end
            if (best != i) begin
                for (k = 0; k < n; k++) begin
                    t = a_mat[i*16+k];
                    a_mat[i*16+k] = a_mat[best*16+k];
                    a_mat[best*16+k] = t;
                end
                t = row_ord[i];
                row_ord[i] = row_ord[best];
                row_ord[best] = t;
            end
        end
        for (i = 0; i < n; i++)
            for (k = 0; k < n; k++) l_mul[i*16+k] = (i == k) ? ONE : 0;
        for (i = 1; i < n; i++) begin
            for (j = 0; j < i; j++) begin
                if (a_mat[j*16+j] == 0) begin
                    res.push_back(singular_sol());
                    return;
                end
                mlt = q_quotient(a_mat[i*16+j], a_mat[j*16+j]);
                l_mul[i*16+j] = mlt;
                for (k = 0; k < n; k++)
                    a_mat[i*16+k] = q_diff(a_mat[i*16+k], q_product(mlt, a_mat[j*16+k]));
            end
        end
        for (i = 0; i < n; i++) begin
            acc = b_vec[row_ord[i]];
            for (j = 0; j < i; j++) acc = q_diff(acc, q_product(l_mul[i*16+j], y[j]));
            y[i] = acc;
        end
        for (i = n - 1; i >= 0; i--) begin
            acc = y[i];
            for (j = i + 1; j < n; j++) acc = q_diff(acc, q_product(a_mat[i*16+j], x_sol[j]));
            d = a_mat[i*16+i];
            if (d == 0) begin
                res.push_back(singular_sol());
                return;
            end
            x_sol[i] = q_quotient(acc, d);
        end
        for (i = 0; i < n; i++) begin
            s.index = 4'(i); s.value = x_sol[i]; s.status = 1'b0; s.done = (i == n - 1);
            res.push_back(s);
        end
    endfunction

    // ek: 0 use the predictor, 1 one typed solution value, 2 singular
    task automatic push_req(logic f, logic [3:0] r, logic [3:0] c, int v, logic l,
                            int ek = 0, int ev = 0);
        t_sol pred [$];
        t_sol s;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                rq.valid = 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        rq.valid = 1'b1; rq.func = f; rq.row = r; rq.col = c; rq.value = v; rq.last = l;
        do @(posedge i_clk); while (!rq.ready);
        burst_left--;
        n_loads++;
        if (f == FN_MAT) begin
            a_mat[r*16+c] = v;
            mat_wr[r*16+c] = 1'b1;
        end else begin
            b_vec[r] = v;
            vec_wr[r] = 1'b1;
        end
        if (l) begin
            lu_solve_predict(pred);
            if (ek == 1) begin
                s.index = '0; s.value = ev; s.status = 1'b0; s.done = 1'b1;
                pred = '{s};
            end else if (ek == 2) begin
                pred = '{singular_sol()};
            end
            foreach (pred[i]) pending_sol.push_back(pred[i]);
            n_solves++;
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        rq.valid = 1'b0;
        wait (pending_sol.size() == 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic apb_cycle(logic wr, logic idx, logic [31:0] d);
        @(negedge i_clk);
        rq.valid = 1'b0;
        psel = 1'b1; penable = 1'b0; pwrite = wr; paddr = {idx, 2'b00}; pwdata = d;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (!wr) begin
            if (prdata != d)
                $error("readback reg %0d: expected %0h, actual %0h", idx, d, prdata);
        end
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    task automatic write_cfg(logic idx, int val);
        logic [31:0] keep;
        if (idx == REG_MSIZE) begin
            cfg_size = 5'(val);
            keep = 32'(cfg_size);
        end else begin
            cfg_thr = 31'(val);
            keep = 32'(cfg_thr);
        end
        apb_cycle(1'b1, idx, 32'(val));
        apb_cycle(1'b0, idx, keep);
    endtask

    function automatic int gen_val(int kind, bit diag);
        int v;
        case (kind)
            1: v = $urandom;
            2: v = ($urandom_range(0, 2) - 1) * ONE;
            default: begin
                v = $urandom_range(0, 8 * ONE) - 4 * ONE;
                if (diag) v += (v < 0) ? -8 * ONE : 8 * ONE;
            end
        endcase
        return v;
    endfunction

    // load one system in shuffled order, optional stray writes first
    task automatic solve_random(int kind);
        t_entry lst [$];
        t_entry e;
        int n, i, j, p, q, noise;
        bit all_set;
        n = eff_size();
        all_set = 1'b1;
        for (i = 0; i < n; i++) begin
            if (!vec_wr[i]) all_set = 1'b0;
            for (j = 0; j < n; j++) if (!mat_wr[i*16+j]) all_set = 1'b0;
        end
        noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        for (i = 0; i < noise; i++) begin
            e.f = 1'($urandom); e.r = 4'($urandom); e.c = 4'($urandom); e.v = $urandom;
            push_req(e.f, e.r, e.c, e.v, 1'b0);
        end
        if (kind == 3 && all_set) begin
            // re-solve on the stored factor with a new vector
            for (i = 0; i < n; i++) begin
                e.f = FN_VEC; e.r = 4'(i); e.c = 4'($urandom); e.v = gen_val(0, 0);
                lst.push_back(e);
            end
        end else begin
            for (i = 0; i < n; i++) begin
                for (j = 0; j < n; j++) begin
                    e.f = FN_MAT; e.r = 4'(i); e.c = 4'(j); e.v = gen_val(kind, i == j);
                    lst.push_back(e);
                end
                e.f = FN_VEC; e.r = 4'(i); e.c = 4'($urandom); e.v = gen_val(kind, 0);
                lst.push_back(e);
            end
        end
        for (p = lst.size() - 1; p > 0; p--) begin
            q = $urandom_range(0, p);
            e = lst[p]; lst[p] = lst[q]; lst[q] = e;
        end
        foreach (lst[i]) begin
            if (i == lst.size() - 1 && hold_asks == 0 && n_solves > 30) hold_asks = 1;
            push_req(lst[i].f, lst[i].r, lst[i].c, lst[i].v, i == lst.size() - 1);
        end
    endtask

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_cnt = HOLD_LEN;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        if (hold_cnt > 0) begin
            hold_cnt--;
            rs.ready = 1'b0;
        end else begin
            case (rx_mode)
                0: rs.ready = 1'b1;
                1: rs.ready = 1'($urandom);
                default: rs.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_sol x;
        if (i_rst_n) begin
            if (rs.valid && rs.ready) begin
                n_results++;
                if (rs.status) n_singular++;
                if (pending_sol.size() == 0) begin
                    $error("unexpected result: index %0d value %0h status %0b",
                           rs.index, rs.value_res, rs.status);
                    n_errors++;
                end else begin
                    x = pending_sol.pop_front();
                    if (rs.index !== x.index) begin
                        $error("index: expected %0d, actual %0d", x.index, rs.index);
                        n_errors++;
                    end
                    if (rs.value_res !== x.value) begin
                        $error("value_res: expected %0h, actual %0h", x.value, rs.value_res);
                        n_errors++;
                    end
                    if (rs.status !== x.status) begin
                        $error("status: expected %0b, actual %0b", x.status, rs.status);
                        n_errors++;
                    end
                    if (rs.done_res !== x.done) begin
                        $error("done_res: expected %0b, actual %0b", x.done, rs.done_res);
                        n_errors++;
                    end
                end
            end
            if ((rs.valid && rs.ready) || (rq.valid && rq.ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", WD_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    t_dir_row dir_tab [25] = '{
        '{1,  0, 0, 0, 0, ONE,        0, 0, 0},
        '{-1, -1, 1, 0, 0, 2*ONE,     1, 1, 2*ONE},
        '{-1, -1, 0, 0, 0, 0,         1, 2, 0},
        '{-1, -1, 0, 0, 0, QMIN,      0, 0, 0},
        '{-1, -1, 1, 0, 0, QMAX,      1, 0, 0},
        '{-1, -1, 0, 0, 0, 1,         0, 0, 0},
        '{-1, -1, 1, 0, 0, QMAX,      1, 1, QMAX},
        '{-1, -1, 1, 0, 0, QMIN,      1, 1, QMIN},
        '{2,  -1, 0, 0, 0, 0,         0, 0, 0},
        '{-1, -1, 0, 0, 1, ONE,       0, 0, 0},
        '{-1, -1, 0, 1, 0, 2*ONE,     0, 0, 0},
        '{-1, -1, 0, 1, 1, 0,         0, 0, 0},
        '{-1, -1, 1, 0, 0, ONE,       0, 0, 0},
        '{-1, -1, 1, 1, 0, 4*ONE,     1, 0, 0},
        '{-1, -1, 0, 0, 0, ONE,       0, 0, 0},
        '{-1, -1, 0, 1, 0, -ONE,      0, 0, 0},
        '{-1, -1, 0, 0, 1, ONE,       0, 0, 0},
        '{-1, -1, 0, 1, 1, 3*ONE,     0, 0, 0},
        '{-1, -1, 1, 0, 0, -ONE,      0, 0, 0},
        '{-1, -1, 1, 1, 0, 5*ONE,     1, 0, 0},
        '{-1, 32'h7FFF_FFFF, 1, 0, 0, ONE, 1, 2, 0},
        '{-1, 0,  0, 0, 0, ONE,       0, 0, 0},
        '{-1, -1, 0, 0, 1, ONE,       0, 0, 0},
        '{-1, -1, 0, 1, 0, ONE,       0, 0, 0},
        '{-1, -1, 0, 1, 1, ONE,       1, 2, 0}
    };

    initial begin
        int kind, pick, prob;
        rq.valid = 1'b0; rq.func = FN_MAT; rq.row = '0; rq.col = '0;
        rq.value = '0; rq.last = 1'b0;
        rs.ready = 1'b0;
        for (int i = 0; i < 16; i++) row_ord[i] = i;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].sz >= 0 || dir_tab[i].thr >= 0) begin
                settle();
                if (dir_tab[i].sz >= 0) write_cfg(REG_MSIZE, dir_tab[i].sz);
                if (dir_tab[i].thr >= 0) write_cfg(REG_THR, dir_tab[i].thr);
            end
            push_req(1'(dir_tab[i].f), 4'(dir_tab[i].r), 4'(dir_tab[i].c), dir_tab[i].v,
                     1'(dir_tab[i].l), dir_tab[i].ek, dir_tab[i].ev);
        end

        // largest system once, through an out-of-range size
        settle();
        write_cfg(REG_MSIZE, 31);
        write_cfg(REG_THR, 0);
        solve_random(0);

        // back to small systems for the random part
        settle();
        write_cfg(REG_MSIZE, $urandom_range(1, 5));

        prob = 0;
        while (n_loads < 460) begin
            // keep the stall from the hold-off: no idle gap right after it
            if (hold_asks == 1 && prob == -1) begin
                prob = 1;
            end else if ($urandom_range(0, 2) == 0) begin
                settle();
                pick = $urandom_range(0, 9);
                write_cfg(REG_MSIZE, pick == 0 ? 0 : (pick == 1 ? 16 : $urandom_range(1, 5)));
                if (eff_size() == 16) write_cfg(REG_MSIZE, $urandom_range(1, 4));
                pick = $urandom_range(0, 9);
                write_cfg(REG_THR, pick < 6 ? 0 :
                                   (pick < 9 ? $urandom_range(0, ONE) : 32'h7FFF_FFFF));
            end
            pick = $urandom_range(0, 9);
            kind = pick < 6 ? 0 : (pick < 8 ? 2 : (pick < 9 ? 1 : 3));
            if (hold_asks == 0) prob = -1;
            solve_random(kind);
        end

        settle();
        $display("Ran %0d load requests in %0d solves; %0d results checked, %0d singular.",
                 n_loads, n_solves, n_results, n_singular);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lu_pkg.sv
hw/rtl/lu_req_if.sv
hw/rtl/lu_res_if.sv
hw/rtl/lu_ram.sv
hw/rtl/lu_div.sv
hw/rtl/lu_linear_solver.sv
tb/sv/tb.sv
